// ===== src/aifp_pkg.sv =====
package aifp_pkg;

    // output value width, fixed by the result format
    localparam int OUT_VALUE_BITS = 64;

    // result status codes, first failed check wins
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_DIGITS  = 3'd1,
        ST_NONNUMERIC = 3'd2,
        ST_NEGATIVE   = 3'd3,
        ST_ZERO       = 3'd4,
        ST_BLANK      = 3'd5
    } t_status;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_NEGATIVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_NONNUMERIC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_ZERO       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH       = 3'd5;

    // radix modes, the unused code acts as decimal
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    // character codes
    localparam logic [7:0] CHR_NUL       = 8'h00;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_MINUS     = 8'h2D;
    localparam logic [7:0] CHR_ZERO      = 8'h30;
    localparam logic [7:0] CHR_EIGHT     = 8'h38;
    localparam logic [7:0] CHR_NINE      = 8'h39;
    localparam logic [7:0] CHR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHR_UPPER_F   = 8'h46;
    localparam logic [7:0] CHR_UPPER_OFS = 8'h37;
    localparam logic [7:0] CHR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHR_LOWER_OFS = 8'h57;

endpackage

// ===== src/aifp_in_if.sv =====
interface aifp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       new_field;

    modport source (output valid, output char_code, output new_field, input ready);
    modport sink (input valid, input char_code, input new_field, output ready);
endinterface

// ===== src/aifp_out_if.sv =====
interface aifp_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [2:0]         status;
    logic               line_end;

    modport source (output valid, output value, output status, output line_end, input ready);
    modport sink (input valid, input value, input status, input line_end, output ready);
endinterface

// ===== src/ascii_integer_field_parser_unit.sv =====
// channel   dir  payload                         transfer when
// i_char    in   char_code[7:0], new_field       valid && ready
// o_result  out  value[63:0], status[2:0], line_end  valid && ready
// i_cfg_*   in   index, data (write only)        i_cfg_we high
//
// one character per cycle while the sink keeps up; the field state is updated in the cycle of the transfer
// and a result lands in the output register in the cycle after its character
// the output register is the only buffer: input is taken whenever it is empty
// or being drained, so a stalled sink stalls the character stream
// synchronous active-low reset clears the field state, the output valid flag and
// the configuration (decimal, all checks off, width 32)
module ascii_integer_field_parser_unit #(
    parameter int MAX_FIELD_WIDTH = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    aifp_in_if.sink                           i_char,
    aifp_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [aifp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [aifp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int POS_W = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int WCMP_W = 7;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_MINUS  = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    // configuration registers
    logic [1:0] r_radix_mode;
    logic       r_scan_mode;
    logic       r_reject_negative;
    logic       r_reject_nonnumeric;
    logic       r_reject_zero;
    logic [5:0] r_field_width;

    // field state
    t_phase                  r_phase, n_phase;
    logic [POS_W-1:0]        r_char_pos, n_char_pos;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic                    r_seen_digit, n_seen_digit;
    logic                    r_seen_stray, n_seen_stray;
    logic                    r_seen_minus, n_seen_minus;

    // output register
    logic                                   r_out_valid;
    logic signed [aifp_pkg::OUT_VALUE_BITS-1:0] r_value, n_value;
    aifp_pkg::t_status                      r_status, n_status;
    logic                                   r_line_end, n_line_end;
    logic                                   n_emit;

    // working signals
    logic                  w_accept;
    logic [WCMP_W-1:0]     w_width;
    logic [WCMP_W-1:0]     w_pos_inc;
    t_phase                s_phase;
    logic [POS_W-1:0]      s_char_pos;
    logic [VALUE_BITS-1:0] s_acc;
    logic                  s_seen_digit, s_seen_stray, s_seen_minus;
    logic [7:0]            w_c;
    logic                  w_is_end, w_is_blank, w_is_minus;
    logic                  w_dig_valid;
    logic [3:0]            w_dig;
    logic [VALUE_BITS-1:0] w_acc_dig;
    logic [VALUE_BITS-1:0] w_fin_val;
    logic                  w_finish, w_fin_le, w_clear, w_restart;

    assign w_accept = i_char.valid && i_char.ready;
    assign i_char.ready = !r_out_valid || o_result.ready;

    assign o_result.valid    = r_out_valid;
    assign o_result.value    = r_value;
    assign o_result.status   = r_status;
    assign o_result.line_end = r_line_end;

    // effective field width, zero acts as one, clamped to the maximum
    always_comb begin
        if (r_field_width == 6'd0) begin
            w_width = WCMP_W'(1);
        end else if (WCMP_W'(r_field_width) > WCMP_W'(MAX_FIELD_WIDTH)) begin
            w_width = WCMP_W'(MAX_FIELD_WIDTH);
        end else begin
            w_width = WCMP_W'(r_field_width);
        end
    end

    // start of step state, new_field drops the partial field
    always_comb begin
        if (i_char.new_field) begin
            s_phase      = PH_SKIP;
            s_char_pos   = '0;
            s_acc        = '0;
            s_seen_digit = 1'b0;
            s_seen_stray = 1'b0;
            s_seen_minus = 1'b0;
        end else begin
            s_phase      = r_phase;
            s_char_pos   = r_char_pos;
            s_acc        = r_acc;
            s_seen_digit = r_seen_digit;
            s_seen_stray = r_seen_stray;
            s_seen_minus = r_seen_minus;
        end
    end

    // character classes
    assign w_c        = i_char.char_code;
    assign w_is_end   = (w_c == aifp_pkg::CHR_NUL) || (w_c == aifp_pkg::CHR_NEWLINE);
    assign w_is_blank = (w_c == aifp_pkg::CHR_SPACE) || (w_c == aifp_pkg::CHR_TAB);
    assign w_is_minus = (w_c == aifp_pkg::CHR_MINUS);
    assign w_pos_inc  = WCMP_W'(s_char_pos) + WCMP_W'(1);

    // digit decode and accumulate
    always_comb begin
        w_dig_valid = 1'b0;
        w_dig       = 4'd0;
        w_acc_dig   = s_acc;
        unique case (r_radix_mode)
            aifp_pkg::RADIX_HEX: begin
                if (w_c >= aifp_pkg::CHR_ZERO && w_c <= aifp_pkg::CHR_NINE) begin
                    w_dig_valid = 1'b1;
                    w_dig       = 4'(w_c - aifp_pkg::CHR_ZERO);
                end else if (w_c >= aifp_pkg::CHR_UPPER_A && w_c <= aifp_pkg::CHR_UPPER_F) begin
                    w_dig_valid = 1'b1;
                    w_dig       = 4'(w_c - aifp_pkg::CHR_UPPER_OFS);
                end else if (w_c >= aifp_pkg::CHR_LOWER_A && w_c <= aifp_pkg::CHR_LOWER_F) begin
                    w_dig_valid = 1'b1;
                    w_dig       = 4'(w_c - aifp_pkg::CHR_LOWER_OFS);
                end
                w_acc_dig = (s_acc << 4) + VALUE_BITS'(w_dig);
            end
            aifp_pkg::RADIX_OCT: begin
                if (w_c >= aifp_pkg::CHR_ZERO && w_c < aifp_pkg::CHR_EIGHT) begin
                    w_dig_valid = 1'b1;
                    w_dig       = 4'(w_c - aifp_pkg::CHR_ZERO);
                end
                w_acc_dig = (s_acc << 3) + VALUE_BITS'(w_dig);
            end
            default: begin
                if (w_c >= aifp_pkg::CHR_ZERO && w_c <= aifp_pkg::CHR_NINE) begin
                    w_dig_valid = 1'b1;
                    w_dig       = 4'(w_c - aifp_pkg::CHR_ZERO);
                end
                w_acc_dig = (s_acc << 3) + (s_acc << 1) + VALUE_BITS'(w_dig);
            end
        endcase
    end

    // field step: phase handling, termination and result selection
    always_comb begin
        n_phase      = s_phase;
        n_char_pos   = s_char_pos;
        n_acc        = s_acc;
        n_seen_digit = s_seen_digit;
        n_seen_stray = s_seen_stray;
        n_seen_minus = s_seen_minus;
        n_emit       = 1'b0;
        n_value      = '0;
        n_status     = aifp_pkg::ST_OK;
        n_line_end   = 1'b0;
        w_finish     = 1'b0;
        w_fin_le     = 1'b0;
        w_clear      = 1'b0;
        w_restart    = 1'b0;
        w_fin_val    = '0;

        if (s_phase == PH_SKIP && w_is_end) begin
            n_emit     = 1'b1;
            n_status   = aifp_pkg::ST_BLANK;
            n_line_end = 1'b1;
            w_clear    = 1'b1;
        end else if (s_phase == PH_SKIP && (w_is_blank || w_is_minus)) begin
            if (w_is_minus) begin
                n_seen_minus = 1'b1;
                n_phase      = PH_MINUS;
            end
            if (w_pos_inc >= w_width) begin
                n_emit   = 1'b1;
                n_status = aifp_pkg::ST_BLANK;
                w_clear  = 1'b1;
            end else begin
                n_char_pos = POS_W'(w_pos_inc);
            end
        end else begin
            n_phase = PH_DIGITS;
            if (!w_dig_valid && w_is_end) begin
                w_finish = 1'b1;
                w_fin_le = 1'b1;
            end else if (!w_dig_valid && w_is_blank && r_scan_mode) begin
                w_finish  = 1'b1;
                w_restart = 1'b1;
            end else begin
                if (w_dig_valid) begin
                    n_acc        = w_acc_dig;
                    n_seen_digit = 1'b1;
                end else if (!w_is_blank) begin
                    n_seen_stray = 1'b1;
                end
                if (w_pos_inc >= w_width) begin
                    w_finish = 1'b1;
                end else begin
                    n_char_pos = POS_W'(w_pos_inc);
                end
            end
        end

        // field result with checks in priority order
        if (w_finish) begin
            n_emit     = 1'b1;
            n_line_end = w_fin_le;
            w_clear    = 1'b1;
            w_fin_val  = n_seen_minus ? (VALUE_BITS'(0) - n_acc) : n_acc;
            if (!n_seen_digit) begin
                n_status = aifp_pkg::ST_NO_DIGITS;
            end else begin
                n_value = aifp_pkg::OUT_VALUE_BITS'(signed'(w_fin_val));
                priority if (r_reject_nonnumeric && n_seen_stray) begin
                    n_status = aifp_pkg::ST_NONNUMERIC;
                end else if (r_reject_negative && w_fin_val[VALUE_BITS-1]) begin
                    n_status = aifp_pkg::ST_NEGATIVE;
                end else if (r_reject_zero && w_fin_val == '0) begin
                    n_status = aifp_pkg::ST_ZERO;
                end else begin
                    n_status = aifp_pkg::ST_OK;
                end
            end
        end

        // field ended: clear, a scan terminator already counts in the next field
        if (w_clear) begin
            n_phase      = PH_SKIP;
            n_acc        = '0;
            n_seen_digit = 1'b0;
            n_seen_stray = 1'b0;
            n_seen_minus = 1'b0;
            n_char_pos   = (w_restart && w_width > WCMP_W'(1)) ? POS_W'(1) : '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_mode        <= aifp_pkg::RADIX_DEC;
            r_scan_mode         <= 1'b0;
            r_reject_negative   <= 1'b0;
            r_reject_nonnumeric <= 1'b0;
            r_reject_zero       <= 1'b0;
            r_field_width       <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aifp_pkg::CFG_RADIX_MODE:        r_radix_mode        <= i_cfg_data[1:0];
                aifp_pkg::CFG_SCAN_MODE:         r_scan_mode         <= i_cfg_data[0];
                aifp_pkg::CFG_REJECT_NEGATIVE:   r_reject_negative   <= i_cfg_data[0];
                aifp_pkg::CFG_REJECT_NONNUMERIC: r_reject_nonnumeric <= i_cfg_data[0];
                aifp_pkg::CFG_REJECT_ZERO:       r_reject_zero       <= i_cfg_data[0];
                aifp_pkg::CFG_FIELD_WIDTH:       r_field_width       <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // field state, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP;
            r_char_pos   <= '0;
            r_acc        <= '0;
            r_seen_digit <= 1'b0;
            r_seen_stray <= 1'b0;
            r_seen_minus <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_char_pos   <= n_char_pos;
            r_acc        <= n_acc;
            r_seen_digit <= n_seen_digit;
            r_seen_stray <= n_seen_stray;
            r_seen_minus <= n_seen_minus;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= n_emit;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_value    <= n_value;
            r_status   <= n_status;
            r_line_end <= n_line_end;
        end
    end

`ifndef SYNTH
    // results without a value carry zero
    a_no_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == aifp_pkg::ST_NO_DIGITS
                         || r_status == aifp_pkg::ST_BLANK)) |-> (r_value == '0))
        else $error("blank or digitless result with nonzero value");

    // a negative status only for a negative value
    a_neg_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == aifp_pkg::ST_NEGATIVE) |-> r_value[63])
        else $error("negative status on a non-negative value");

    // skip phase holds no digits and an empty accumulator
    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (!r_seen_digit && !r_seen_stray && r_acc == '0))
        else $error("skip phase with field content");

    // minus phase only after a minus sign
    a_minus_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MINUS) |-> (r_seen_minus && !r_seen_digit))
        else $error("minus phase without minus sign");

    // a result is only loaded by an input transfer
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept))
        else $error("result appeared without an input transfer");
`endif

endmodule
